// ----- design/code128b_symbol_encoder_core_defines.svh -----
// Assertion helpers for the checker file of the symbol encoder.
`ifndef CODE128B_SYMBOL_ENCODER_CORE_DEFINES_SVH
`define CODE128B_SYMBOL_ENCODER_CORE_DEFINES_SVH

// Check a consequent in the same cycle as its antecedent.
`define CBE_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check a consequent in the cycle after its antecedent.
`define CBE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/cbe_pkg.sv -----
package cbe_pkg;

    // Symbol kind codes, also used as the emit phase
    localparam logic [1:0] KIND_START = 2'd0;
    localparam logic [1:0] KIND_DATA  = 2'd1;
    localparam logic [1:0] KIND_CKS   = 2'd2;
    localparam logic [1:0] KIND_STOP  = 2'd3;

    localparam logic [6:0]  START_B_VALUE = 7'd104;
    localparam logic [6:0]  CHECK_MOD     = 7'd103;
    localparam logic [6:0]  FIRST_WEIGHT  = 7'd1;
    // Start B value reduced modulo 103
    localparam logic [6:0]  START_B_RES   = 7'd1;
    localparam logic [12:0] STOP_PATTERN  = 13'h18EB;
    localparam logic [3:0]  SYM_MODULES   = 4'd11;
    localparam logic [3:0]  STOP_MODULES  = 4'd13;
    // 128 modulo 103, used to fold the weighted product
    localparam logic [4:0]  FOLD_FACTOR   = 5'd25;
    localparam logic [7:0]  CHAR_BASE     = 8'd32;

    typedef struct packed {
        logic [7:0] char_code;
        logic       last_char;
    } t_in_word;

    typedef struct packed {
        logic [12:0] pattern;
        logic [3:0]  module_count;
        logic [1:0]  symbol_kind;
        logic        end_of_run;
    } t_out_word;

    // Item after value mapping and weight assignment
    typedef struct packed {
        logic [6:0] val;
        logic [6:0] weight;
        logic       need_start;
        logic       last;
    } t_item;

    // Item with its weighted term reduced modulo 103
    typedef struct packed {
        logic [6:0] val;
        logic [6:0] term;
        logic       need_start;
        logic       last;
    } t_term_word;

    // Code 128 symbol patterns, 11 modules each
    function automatic logic [10:0] sym_pattern(input logic [6:0] idx);
        logic [10:0] p;
        case (idx)
            7'd0:   p = 11'h6CC;  7'd1:   p = 11'h66C;  7'd2:   p = 11'h666;
            7'd3:   p = 11'h498;  7'd4:   p = 11'h48C;  7'd5:   p = 11'h44C;
            7'd6:   p = 11'h4C8;  7'd7:   p = 11'h4C4;  7'd8:   p = 11'h464;
            7'd9:   p = 11'h648;  7'd10:  p = 11'h644;  7'd11:  p = 11'h624;
            7'd12:  p = 11'h59C;  7'd13:  p = 11'h4DC;  7'd14:  p = 11'h4CE;
            7'd15:  p = 11'h5CC;  7'd16:  p = 11'h4EC;  7'd17:  p = 11'h4E6;
            7'd18:  p = 11'h672;  7'd19:  p = 11'h65C;  7'd20:  p = 11'h64E;
            7'd21:  p = 11'h6E4;  7'd22:  p = 11'h674;  7'd23:  p = 11'h76E;
            7'd24:  p = 11'h74C;  7'd25:  p = 11'h72C;  7'd26:  p = 11'h726;
            7'd27:  p = 11'h764;  7'd28:  p = 11'h734;  7'd29:  p = 11'h732;
            7'd30:  p = 11'h6D8;  7'd31:  p = 11'h6C6;  7'd32:  p = 11'h636;
            7'd33:  p = 11'h518;  7'd34:  p = 11'h458;  7'd35:  p = 11'h446;
            7'd36:  p = 11'h588;  7'd37:  p = 11'h468;  7'd38:  p = 11'h462;
            7'd39:  p = 11'h688;  7'd40:  p = 11'h628;  7'd41:  p = 11'h622;
            7'd42:  p = 11'h5B8;  7'd43:  p = 11'h58E;  7'd44:  p = 11'h46E;
            7'd45:  p = 11'h5D8;  7'd46:  p = 11'h5C6;  7'd47:  p = 11'h476;
            7'd48:  p = 11'h776;  7'd49:  p = 11'h68E;  7'd50:  p = 11'h62E;
            7'd51:  p = 11'h6E8;  7'd52:  p = 11'h6E2;  7'd53:  p = 11'h6EE;
            7'd54:  p = 11'h758;  7'd55:  p = 11'h746;  7'd56:  p = 11'h716;
            7'd57:  p = 11'h768;  7'd58:  p = 11'h762;  7'd59:  p = 11'h71A;
            7'd60:  p = 11'h77A;  7'd61:  p = 11'h642;  7'd62:  p = 11'h78A;
            7'd63:  p = 11'h530;  7'd64:  p = 11'h50C;  7'd65:  p = 11'h4B0;
            7'd66:  p = 11'h486;  7'd67:  p = 11'h42C;  7'd68:  p = 11'h426;
            7'd69:  p = 11'h590;  7'd70:  p = 11'h584;  7'd71:  p = 11'h4D0;
            7'd72:  p = 11'h4C2;  7'd73:  p = 11'h434;  7'd74:  p = 11'h432;
            7'd75:  p = 11'h612;  7'd76:  p = 11'h650;  7'd77:  p = 11'h7BA;
            7'd78:  p = 11'h614;  7'd79:  p = 11'h47A;  7'd80:  p = 11'h53C;
            7'd81:  p = 11'h4BC;  7'd82:  p = 11'h49E;  7'd83:  p = 11'h5E4;
            7'd84:  p = 11'h4F4;  7'd85:  p = 11'h4F2;  7'd86:  p = 11'h7A4;
            7'd87:  p = 11'h794;  7'd88:  p = 11'h792;  7'd89:  p = 11'h6DE;
            7'd90:  p = 11'h6F6;  7'd91:  p = 11'h7B6;  7'd92:  p = 11'h578;
            7'd93:  p = 11'h51E;  7'd94:  p = 11'h45E;  7'd95:  p = 11'h5E8;
            7'd96:  p = 11'h5E2;  7'd97:  p = 11'h7A8;  7'd98:  p = 11'h7A2;
            7'd99:  p = 11'h5DE;  7'd100: p = 11'h5EE;  7'd101: p = 11'h75E;
            7'd102: p = 11'h7AE;  7'd103: p = 11'h684;  7'd104: p = 11'h690;
            7'd105: p = 11'h69C;
            default: p = 11'h000;
        endcase
        return p;
    endfunction

endpackage

// ----- design/cbe_front.sv -----
module cbe_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  cbe_pkg::t_in_word i_in_word,
    output logic             o_valid,
    output cbe_pkg::t_item   o_item,
    input  logic             i_ready
);

    logic           r_valid;
    cbe_pkg::t_item r_item;
    logic [6:0]     r_weight;
    logic           r_in_msg;

    logic           accept;
    logic           in_range;
    logic [6:0]     item_weight;
    logic [6:0]     n_weight;
    logic [7:0]     char_off;
    cbe_pkg::t_item n_item;

    assign o_in_ready = !r_valid || i_ready;
    assign accept     = i_in_valid && o_in_ready;

    // Map the byte to a set B value, substitute space when out of range
    assign in_range = !i_in_word.char_code[7] && (i_in_word.char_code[6:5] != 2'b00);
    assign char_off = i_in_word.char_code - cbe_pkg::CHAR_BASE;

    // Position weight restarts with each message and wraps modulo 103
    assign item_weight = r_in_msg ? r_weight : cbe_pkg::FIRST_WEIGHT;
    always_comb begin
        if (item_weight == cbe_pkg::CHECK_MOD - 7'd1) begin
            n_weight = 7'd0;
        end else begin
            n_weight = item_weight + 7'd1;
        end
    end

    always_comb begin
        n_item.val        = in_range ? char_off[6:0] : 7'd0;
        n_item.weight     = item_weight;
        n_item.need_start = !r_in_msg;
        n_item.last       = i_in_word.last_char;
    end

    // Track message position at acceptance
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= 1'b0;
            r_in_msg <= 1'b0;
            r_weight <= cbe_pkg::FIRST_WEIGHT;
        end else begin
            if (o_in_ready) begin
                r_valid <= i_in_valid;
            end
            if (accept) begin
                r_in_msg <= !i_in_word.last_char;
                r_weight <= i_in_word.last_char ? cbe_pkg::FIRST_WEIGHT : n_weight;
            end
        end
    end

    // Hold the input word
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item <= n_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

// ----- design/cbe_wsum.sv -----
module cbe_wsum (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  cbe_pkg::t_item      i_item,
    output logic                o_ready,
    output logic                o_valid,
    output cbe_pkg::t_term_word o_word,
    input  logic                i_ready
);

    typedef struct packed {
        logic [6:0]  val;
        logic [13:0] prod;
        logic        need_start;
        logic        last;
    } t_prod_word;

    logic                r_s1_valid;
    t_prod_word          r_s1;
    logic                r_s2_valid;
    cbe_pkg::t_term_word r_s2;

    logic        s1_free;
    logic        s2_free;
    logic [10:0] fold1;
    logic [8:0]  fold2;
    logic [7:0]  fold3;
    logic [7:0]  term8;
    logic [6:0]  term;

    assign s2_free = !r_s2_valid || i_ready;
    assign s1_free = !r_s1_valid || s2_free;
    assign o_ready = s1_free;

    // Fold the product modulo 103 using 128 = 25 (mod 103)
    always_comb begin
        fold1 = 11'(r_s1.prod[13:7]) * 11'(cbe_pkg::FOLD_FACTOR) + 11'(r_s1.prod[6:0]);
        fold2 = 9'(fold1[10:7]) * 9'(cbe_pkg::FOLD_FACTOR) + 9'(fold1[6:0]);
        fold3 = 8'(fold2[8:7]) * 8'(cbe_pkg::FOLD_FACTOR) + 8'(fold2[6:0]);
        if (fold3 >= 8'(cbe_pkg::CHECK_MOD)) begin
            term8 = fold3 - 8'(cbe_pkg::CHECK_MOD);
        end else begin
            term8 = fold3;
        end
        term = term8[6:0];
    end

    // Advance valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else begin
            if (s1_free) begin
                r_s1_valid <= i_valid;
            end
            if (s2_free) begin
                r_s2_valid <= r_s1_valid;
            end
        end
    end

    // Multiply value by weight, then reduce
    always_ff @(posedge i_clk) begin
        if (s1_free && i_valid) begin
            r_s1.val        <= i_item.val;
            r_s1.prod       <= 14'(i_item.val) * 14'(i_item.weight);
            r_s1.need_start <= i_item.need_start;
            r_s1.last       <= i_item.last;
        end
        if (s2_free && r_s1_valid) begin
            r_s2.val        <= r_s1.val;
            r_s2.term       <= term;
            r_s2.need_start <= r_s1.need_start;
            r_s2.last       <= r_s1.last;
        end
    end

    assign o_valid = r_s2_valid;
    assign o_word  = r_s2;

endmodule

// ----- design/cbe_emit.sv -----
module cbe_emit (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  cbe_pkg::t_term_word i_word,
    output logic                o_ready,
    output logic                o_out_valid,
    output cbe_pkg::t_out_word  o_out_word,
    input  logic                i_out_ready
);

    typedef struct packed {
        logic [6:0] val;
        logic [6:0] cks;
        logic       last;
    } t_sym_word;

    logic               r_acc;
    logic [6:0]         r_acc_val;
    logic               r_s3_valid;
    t_sym_word          r_s3;
    logic [1:0]         r_phase;
    logic               r_out_valid;
    cbe_pkg::t_out_word r_out;

    logic               out_free;
    logic               final_sym;
    logic               s3_free;
    logic               load;
    logic [6:0]         base;
    logic [7:0]         sum;
    logic [6:0]         n_cks;
    logic [1:0]         n_phase;
    cbe_pkg::t_out_word n_out;

    assign out_free  = !r_out_valid || i_out_ready;
    assign final_sym = ((r_phase == cbe_pkg::KIND_DATA) && !r_s3.last)
                     || (r_phase == cbe_pkg::KIND_STOP);
    assign s3_free   = !r_s3_valid || (out_free && final_sym);
    assign o_ready   = s3_free;
    assign load      = s3_free && i_valid;

    // Accumulate the checksum in message order
    always_comb begin
        base = (i_word.need_start || !r_acc) ? cbe_pkg::START_B_RES : r_acc_val;
        sum  = 8'(base) + 8'(i_word.term);
        if (sum >= 8'(cbe_pkg::CHECK_MOD)) begin
            n_cks = 7'(sum - 8'(cbe_pkg::CHECK_MOD));
        end else begin
            n_cks = sum[6:0];
        end
    end

    // Select the symbol of the current phase
    always_comb begin
        n_out.module_count = cbe_pkg::SYM_MODULES;
        n_out.symbol_kind  = r_phase;
        n_out.end_of_run   = final_sym;
        n_phase            = r_phase;
        case (r_phase)
            cbe_pkg::KIND_START: begin
                n_out.pattern = {2'b00, cbe_pkg::sym_pattern(cbe_pkg::START_B_VALUE)};
                n_phase       = cbe_pkg::KIND_DATA;
            end
            cbe_pkg::KIND_DATA: begin
                n_out.pattern = {2'b00, cbe_pkg::sym_pattern(r_s3.val)};
                n_phase       = cbe_pkg::KIND_CKS;
            end
            cbe_pkg::KIND_CKS: begin
                n_out.pattern = {2'b00, cbe_pkg::sym_pattern(r_s3.cks)};
                n_phase       = cbe_pkg::KIND_STOP;
            end
            cbe_pkg::KIND_STOP: begin
                n_out.pattern      = cbe_pkg::STOP_PATTERN;
                n_out.module_count = cbe_pkg::STOP_MODULES;
            end
            default: begin
                n_out.pattern = 13'd0;
            end
        endcase
    end

    // Sequence the symbols of the held item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc       <= 1'b0;
            r_acc_val   <= cbe_pkg::START_B_RES;
            r_s3_valid  <= 1'b0;
            r_phase     <= cbe_pkg::KIND_START;
            r_out_valid <= 1'b0;
        end else begin
            if (s3_free) begin
                r_s3_valid <= i_valid;
            end
            if (load) begin
                r_acc     <= 1'b1;
                r_acc_val <= n_cks;
                r_phase   <= i_word.need_start ? cbe_pkg::KIND_START : cbe_pkg::KIND_DATA;
            end else if (r_s3_valid && out_free && !final_sym) begin
                r_phase <= n_phase;
            end
            if (out_free) begin
                r_out_valid <= r_s3_valid;
            end
        end
    end

    // Hold the symbol word and the output word
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_s3.val  <= i_word.val;
            r_s3.cks  <= n_cks;
            r_s3.last <= i_word.last;
        end
        if (out_free && r_s3_valid) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

endmodule

// ----- design/code128b_symbol_encoder_core.sv -----
// Code 128 set B symbol encoder.
// Input channel (i_in_valid / o_in_ready, i_in_word): one message character
// per word, with last_char marking the final character of a message.
// Output channel (o_out_valid / i_out_ready, o_out_word): one symbol per word,
// MSB-first module pattern, right aligned. The first character of a message
// yields Start B then its data symbol; the last one adds checksum and stop.
// end_of_run flags the final symbol produced by a character.
// The first symbol of a character passes the front register, the product and
// term registers and the symbol register before it reaches the output register.
// Throughput: one character per cycle in the middle of a message while the
// output is not stalled; a character that causes several symbols holds the
// emit stage until its last symbol is sent. The emit stage, which sends one
// symbol a cycle while the receiver takes them, sets the character rate.
// Reset clears all valid flags, drops any words in flight and starts a new
// message.
// When the receiver stalls, the output word holds and the pipeline behind it
// fills, after which o_in_ready drops until words drain.
module code128b_symbol_encoder_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  cbe_pkg::t_in_word  i_in_word,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output cbe_pkg::t_out_word o_out_word
);

    logic                s0_valid;
    logic                s0_ready;
    cbe_pkg::t_item      s0_item;
    logic                s2_valid;
    logic                s2_ready;
    cbe_pkg::t_term_word s2_word;

    // Map characters and assign position weights
    cbe_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_word  (i_in_word),
        .o_valid    (s0_valid),
        .o_item     (s0_item),
        .i_ready    (s0_ready)
    );

    // Form the weighted checksum term
    cbe_wsum u_wsum (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s0_valid),
        .i_item  (s0_item),
        .o_ready (s0_ready),
        .o_valid (s2_valid),
        .o_word  (s2_word),
        .i_ready (s2_ready)
    );

    // Accumulate and emit symbols
    cbe_emit u_emit (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (s2_valid),
        .i_word      (s2_word),
        .o_ready     (s2_ready),
        .o_out_valid (o_out_valid),
        .o_out_word  (o_out_word),
        .i_out_ready (i_out_ready)
    );

endmodule

// ----- design/cbe_checker.sv -----
`include "code128b_symbol_encoder_core_defines.svh"

module cbe_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_ready,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input cbe_pkg::t_out_word o_out_word
);

    logic in_take;
    logic out_take;

    assign in_take  = i_in_valid && o_in_ready;
    assign out_take = o_out_valid && i_out_ready;

    // A stalled output word holds
    `CBE_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid && $stable(o_out_word), "stalled output word changed")

    // Start is always followed at once by a data symbol
    `CBE_ASSERT_NEXT(a_start_then_data, i_clk, i_rst_n, out_take && (o_out_word.symbol_kind == cbe_pkg::KIND_START), o_out_valid && (o_out_word.symbol_kind == cbe_pkg::KIND_DATA), "start not followed by data")

    // Checksum is always followed at once by stop
    `CBE_ASSERT_NEXT(a_cks_then_stop, i_clk, i_rst_n, out_take && (o_out_word.symbol_kind == cbe_pkg::KIND_CKS), o_out_valid && (o_out_word.symbol_kind == cbe_pkg::KIND_STOP), "checksum not followed by stop")

    // Stop, which closes the run, has the long pattern; others do not
    `CBE_ASSERT_SAME(a_stop_shape, i_clk, i_rst_n, o_out_valid, (o_out_word.symbol_kind == cbe_pkg::KIND_STOP) == (o_out_word.module_count == cbe_pkg::STOP_MODULES), "module count does not match symbol kind")

    // No output word follows the first cycle out of reset if that cycle accepts no character
    `CBE_ASSERT_NEXT(a_no_spurious, i_clk, i_rst_n, !$past(i_rst_n) && !in_take, !o_out_valid, "output word without input")

endmodule

bind code128b_symbol_encoder_core cbe_checker u_cbe_checker (.*);

// ----- tb/sv/tb.sv -----
module tb;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               in_valid = 1'b0;
    cbe_pkg::t_in_word  in_word = '0;
    logic               out_ready = 1'b0;
    logic               o_in_ready;
    logic               o_out_valid;
    cbe_pkg::t_out_word o_out_word;

    // Characters waiting to be driven, symbols waiting to be seen
    cbe_pkg::t_in_word  char_q[$];
    cbe_pkg::t_out_word symbol_q[$];

    // Encoder state as the predictor sees it
    int unsigned cks_acc;
    int unsigned pos_weight;
    bit          mid_message;

    int unsigned in_gap;
    int unsigned out_stall;
    bit          quiet_phase = 1'b0;
    bit          failed = 1'b0;
    int unsigned item_total;

    // Code 128 module patterns, indexed by symbol value
    logic [10:0] bar_table [106] = '{
        11'h6CC, 11'h66C, 11'h666, 11'h498, 11'h48C, 11'h44C, 11'h4C8, 11'h4C4,
        11'h464, 11'h648, 11'h644, 11'h624, 11'h59C, 11'h4DC, 11'h4CE, 11'h5CC,
        11'h4EC, 11'h4E6, 11'h672, 11'h65C, 11'h64E, 11'h6E4, 11'h674, 11'h76E,
        11'h74C, 11'h72C, 11'h726, 11'h764, 11'h734, 11'h732, 11'h6D8, 11'h6C6,
        11'h636, 11'h518, 11'h458, 11'h446, 11'h588, 11'h468, 11'h462, 11'h688,
        11'h628, 11'h622, 11'h5B8, 11'h58E, 11'h46E, 11'h5D8, 11'h5C6, 11'h476,
        11'h776, 11'h68E, 11'h62E, 11'h6E8, 11'h6E2, 11'h6EE, 11'h758, 11'h746,
        11'h716, 11'h768, 11'h762, 11'h71A, 11'h77A, 11'h642, 11'h78A, 11'h530,
        11'h50C, 11'h4B0, 11'h486, 11'h42C, 11'h426, 11'h590, 11'h584, 11'h4D0,
        11'h4C2, 11'h434, 11'h432, 11'h612, 11'h650, 11'h7BA, 11'h614, 11'h47A,
        11'h53C, 11'h4BC, 11'h49E, 11'h5E4, 11'h4F4, 11'h4F2, 11'h7A4, 11'h794,
        11'h792, 11'h6DE, 11'h6F6, 11'h7B6, 11'h578, 11'h51E, 11'h45E, 11'h5E8,
        11'h5E2, 11'h7A8, 11'h7A2, 11'h5DE, 11'h5EE, 11'h75E, 11'h7AE, 11'h684,
        11'h690, 11'h69C
    };

    code128b_symbol_encoder_core u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_word   (in_word),
        .o_out_valid (o_out_valid),
        .i_out_ready (out_ready),
        .o_out_word  (o_out_word)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Queue one expected symbol
    task automatic push_symbol(input logic [12:0] pat, input logic [3:0] cnt,
                               input logic [1:0] kind);
        cbe_pkg::t_out_word s;
        s.pattern      = pat;
        s.module_count = cnt;
        s.symbol_kind  = kind;
        s.end_of_run   = 1'b0;
        symbol_q.push_back(s);
    endtask

    // Work out the symbols one accepted character produces
    task automatic encode_char(input cbe_pkg::t_in_word w);
        int unsigned val;
        if (!mid_message) begin
            cks_acc    = 32'(cbe_pkg::START_B_VALUE);
            pos_weight = 1;
            push_symbol({2'b00, bar_table[cbe_pkg::START_B_VALUE]}, cbe_pkg::SYM_MODULES,
                        cbe_pkg::KIND_START);
        end
        if (w.char_code >= cbe_pkg::CHAR_BASE && w.char_code <= 8'd127) begin
            val     = 32'(w.char_code) - 32'(cbe_pkg::CHAR_BASE);
            cks_acc = (cks_acc + val * pos_weight) % 32'(cbe_pkg::CHECK_MOD);
        end else begin
            val = 0;
        end
        push_symbol({2'b00, bar_table[val]}, cbe_pkg::SYM_MODULES, cbe_pkg::KIND_DATA);
        pos_weight = (pos_weight + 1) % 32'(cbe_pkg::CHECK_MOD);
        if (w.last_char) begin
            push_symbol({2'b00, bar_table[cks_acc % 32'(cbe_pkg::CHECK_MOD)]},
                        cbe_pkg::SYM_MODULES, cbe_pkg::KIND_CKS);
            push_symbol(cbe_pkg::STOP_PATTERN, cbe_pkg::STOP_MODULES, cbe_pkg::KIND_STOP);
            cks_acc     = 32'(cbe_pkg::START_B_VALUE);
            pos_weight  = 1;
            mid_message = 1'b0;
        end else begin
            mid_message = 1'b1;
        end
        symbol_q[symbol_q.size() - 1].end_of_run = 1'b1;
    endtask

    // Mostly short gaps, a few long ones, none in a quiet phase
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 15);
        if (quiet_phase || r < 9)
            return 0;
        else if (r < 14)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 30);
    endfunction

    function automatic logic [7:0] pick_char();
        if ($urandom_range(0, 9) < 8)
            return 8'($urandom_range(32, 127));
        else
            return 8'($urandom_range(0, 255));
    endfunction

    task automatic add_char(input logic [7:0] c, input logic last);
        cbe_pkg::t_in_word w;
        w.char_code = c;
        w.last_char = last;
        char_q.push_back(w);
        item_total++;
    endtask

    task automatic add_message(input int unsigned len);
        for (int unsigned k = 0; k < len; k++)
            add_char(pick_char(), k == len - 1);
    endtask

    // Switch between stretches with random gaps and back-to-back stretches now and then
    always @(posedge i_clk) begin
        if ($urandom_range(0, 199) == 0)
            quiet_phase <= !quiet_phase;
    end

    // Drive characters from the queue, predict each accepted word
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
            in_gap   <= 0;
        end else begin
            if (in_valid && o_in_ready)
                encode_char(in_word);
            if (!in_valid || o_in_ready) begin
                if (in_gap > 0) begin
                    in_gap   <= in_gap - 1;
                    in_valid <= 1'b0;
                end else if (char_q.size() > 0) begin
                    in_word  <= char_q.pop_front();
                    in_valid <= 1'b1;
                    in_gap   <= pick_gap();
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Check each accepted symbol against the oldest expectation
    always @(posedge i_clk) begin
        cbe_pkg::t_out_word exp_sym;
        if (!i_rst_n) begin
            out_ready <= 1'b0;
            out_stall <= 0;
        end else begin
            if (o_out_valid && out_ready) begin
                if (symbol_q.size() == 0) begin
                    $error("unexpected symbol word %h", o_out_word);
                    failed = 1'b1;
                end else begin
                    exp_sym = symbol_q.pop_front();
                    if (o_out_word.pattern !== exp_sym.pattern) begin
                        $error("pattern: expected %h, actual %h",
                               exp_sym.pattern, o_out_word.pattern);
                        failed = 1'b1;
                    end
                    if (o_out_word.module_count !== exp_sym.module_count) begin
                        $error("module_count: expected %0d, actual %0d",
                               exp_sym.module_count, o_out_word.module_count);
                        failed = 1'b1;
                    end
                    if (o_out_word.symbol_kind !== exp_sym.symbol_kind) begin
                        $error("symbol_kind: expected %0d, actual %0d",
                               exp_sym.symbol_kind, o_out_word.symbol_kind);
                        failed = 1'b1;
                    end
                    if (o_out_word.end_of_run !== exp_sym.end_of_run) begin
                        $error("end_of_run: expected %0d, actual %0d",
                               exp_sym.end_of_run, o_out_word.end_of_run);
                        failed = 1'b1;
                    end
                end
            end
            // Hold ready low through a stall, then release it
            if (out_stall > 0) begin
                out_stall <= out_stall - 1;
                out_ready <= 1'b0;
            end else begin
                out_ready <= 1'b1;
                out_stall <= pick_gap();
            end
        end
    end

    initial begin
        cks_acc     = 32'(cbe_pkg::START_B_VALUE);
        pos_weight  = 1;
        mid_message = 1'b0;
        item_total  = 0;

        // Single-character messages at the range edges and outside it
        add_char(8'd32, 1'b1);
        add_char(8'd127, 1'b1);
        add_char(8'd0, 1'b1);
        add_char(8'd255, 1'b1);
        add_char(8'd31, 1'b1);
        add_char(8'd128, 1'b1);
        // Mixed message with substituted bytes in the middle
        add_char(8'd65, 1'b0);
        add_char(8'd0, 1'b0);
        add_char(8'd127, 1'b0);
        add_char(8'd200, 1'b0);
        add_char(8'd32, 1'b0);
        add_char(8'd126, 1'b0);
        add_char(8'd90, 1'b1);
        add_char(8'd65, 1'b0);
        add_char(8'd66, 1'b1);

        // One message long enough to wrap the position weight
        add_message(120);
        while (item_total < 410) begin
            if ($urandom_range(0, 11) == 0)
                add_message($urandom_range(20, 40));
            else
                add_message($urandom_range(1, 8));
        end

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (char_q.size() != 0 || in_valid || symbol_q.size() != 0)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        if (!failed && symbol_q.size() == 0)
            $display("[code128b_symbol_encoder_core] OK");
        else
            $display("[code128b_symbol_encoder_core] ERROR");
        $finish;
    end

    // Give up on a hung run
    initial begin
        #1000000;
        $display("[code128b_symbol_encoder_core] ERROR");
        $finish;
    end

endmodule
